>>> sv/bloom_filter_bit_array_unit_assert.svh
// assertion macros for the bloom filter bit array unit
`ifndef BLOOM_FILTER_BIT_ARRAY_UNIT_ASSERT_SVH
`define BLOOM_FILTER_BIT_ARRAY_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define BF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BF_ASSERT(lbl, clk, rst_n, prop)
`define BF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/bfba_pkg.sv
// shared types and constants of the bloom filter bit array unit
package bfba_pkg;
  localparam int unsigned CfgWidth = 13;
  localparam int unsigned HashWidth = 64;
  localparam int unsigned CountWidth = 13;
  localparam logic [0:0] RegBitArraySize = 1'b0;
  localparam logic [0:0] RegProbeCount = 1'b1;
  localparam logic ActAdd = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [HashWidth-1:0] key_hash;
  } probe_req_t;

  typedef struct packed {
    logic                  maybe_present;
    logic [CountWidth-1:0] set_bit_count;
  } probe_rsp_t;

  typedef struct packed {
    logic load;      // latch item, start modulo
    logic mod_step;  // one remainder bit
    logic clr_step;  // one clearing step
    logic probe;     // read the store at the current position
    logic mark;      // set the store bit at the current position
    logic advance;   // next probe position
  } bfba_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic clr_last;
    logic probe_last;
    logic bit_hit;   // registered store bit of the current position
    logic is_query;
  } bfba_sts_t;
endpackage

>>> sv/bfba_if.sv
// valid/ready channel interface
interface bfba_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/bloom_filter_bit_array_unit.sv
// bloom filter bit array unit top level
// result: after the input transfer, a bit-serial modulo pass over the hash, then a read and
// a check per probe (a query stops at its first clear bit); the result is held until taken
// one item at a time: a new item is accepted only after the last result has been taken
// reset: config to m=4093, k=3 and counter to zero at once, then a clearing pass of the store
module bloom_filter_bit_array_unit import bfba_pkg::*; #(
  parameter int unsigned MaxBits = 4096,
  parameter int unsigned MaxProbes = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  bfba_if.sink                in_if,
  bfba_if.source              out_if
);
  // the clearing pass zeroes the bit store, input not ready meanwhile
  logic [CfgWidth-1:0] size_q;
  logic [4:0] probes_q;
  bfba_cmd_t cmd;
  bfba_sts_t sts;
  logic pres;
  logic [CountWidth-1:0] cnt;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CfgWidth'(4093);
      probes_q <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegBitArraySize: size_q <= cfg_data_i;
        RegProbeCount: probes_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // sequencer: owns both handshakes and the query answer
  bfba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .maybe_present_o(pres), .cmd_o(cmd), .sts_i(sts)
  );

  // datapath: item latched at the input transfer, so the input may change afterwards
  bfba_datapath #(.MaxBits(MaxBits), .MaxProbes(MaxProbes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i(in_if.data.action), .key_hash_i(in_if.data.key_hash),
    .bit_array_size_i(size_q), .probe_count_i(probes_q), .set_bit_count_o(cnt)
  );

  assign out_if.data.maybe_present = pres;
  assign out_if.data.set_bit_count = cnt;
endmodule

>>> sv/bfba_datapath.sv
// modulo unit, probe position, bit store and set-bit counter
module bfba_datapath import bfba_pkg::*; #(
  parameter int unsigned MaxBits = 4096,
  parameter int unsigned MaxProbes = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bfba_cmd_t                cmd_i,
  output bfba_sts_t                sts_o,
  input  logic                     action_i,
  input  logic [HashWidth-1:0]     key_hash_i,
  input  logic [CfgWidth-1:0]      bit_array_size_i,
  input  logic [4:0]               probe_count_i,
  output logic [CountWidth-1:0]    set_bit_count_o
);
  localparam int unsigned AW = (MaxBits > 1) ? $clog2(MaxBits) : 1;
  localparam int unsigned MW = $clog2(MaxBits + 1);
  localparam int unsigned PW = $clog2(MaxProbes + 1);
  localparam int unsigned SW = (CountWidth > MW) ? CountWidth : MW;
  localparam int unsigned HcW = $clog2(HashWidth + 1);

  logic [MW-1:0] m;
  logic [PW-1:0] k;
  always_comb begin
    if (bit_array_size_i == '0) m = MW'(1);
    else if (32'(bit_array_size_i) > MaxBits) m = MW'(MaxBits);
    else m = MW'(bit_array_size_i);
    if (probe_count_i == '0) k = PW'(1);
    else if (32'(probe_count_i) > MaxProbes) k = PW'(MaxProbes);
    else k = PW'(probe_count_i);
  end

  logic [MW-1:0] m_q, rem_q, pos_q, c_q, stepc_q;
  logic [PW-1:0] k_q, pcnt_q;
  logic [HashWidth-1:0] h_q, sum_q;
  logic [HcW-1:0] bit_q;
  logic act_q;
  logic [AW-1:0] clr_q;
  logic [SW-1:0] ones_q;
  logic mem_q [MaxBits];
  logic rd_q;

  logic [MW:0] m_ext, rem_sh, rem_dif, pw_sh, pw_dif, pos_sum, pos_dif, sc_wrap;
  logic [MW-1:0] rem_nxt, pw_nxt, pos_nxt, step_sel, stepc_nxt;
  logic [HashWidth:0] sum_add;
  logic [AW-1:0] addr;

  assign m_ext = {1'b0, m_q};
  // restoring remainder of the hash, one bit per cycle
  assign rem_sh = {rem_q, h_q[HashWidth-1]};
  assign rem_dif = rem_sh - m_ext;
  assign rem_nxt = (rem_sh >= m_ext) ? rem_dif[MW-1:0] : rem_sh[MW-1:0];
  // 2^64 mod m, built alongside by doubling
  assign pw_sh = {c_q, 1'b0};
  assign pw_dif = pw_sh - m_ext;
  assign pw_nxt = (pw_sh >= m_ext) ? pw_dif[MW-1:0] : pw_sh[MW-1:0];
  // a wrap of the 64-bit probe sum takes 2^64 mod m off the position
  assign sum_add = {1'b0, sum_q} + {1'b0, h_q};
  assign step_sel = sum_add[HashWidth] ? stepc_q : rem_q;
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_sel};
  assign pos_dif = pos_sum - m_ext;
  assign pos_nxt = (pos_sum >= m_ext) ? pos_dif[MW-1:0] : pos_sum[MW-1:0];
  assign sc_wrap = {1'b0, rem_q} + m_ext - {1'b0, c_q};
  assign stepc_nxt = (rem_q >= c_q) ? (rem_q - c_q) : sc_wrap[MW-1:0];
  assign addr = pos_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
      rem_q <= '0;
      pos_q <= '0;
      c_q <= '0;
      stepc_q <= '0;
      k_q <= '0;
      pcnt_q <= '0;
      h_q <= '0;
      sum_q <= '0;
      bit_q <= '0;
      act_q <= 1'b0;
      clr_q <= '0;
      ones_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.mark) ones_q <= ones_q + SW'(1);
      if (cmd_i.load) begin
        h_q <= key_hash_i;
        sum_q <= key_hash_i;
        act_q <= action_i;
        m_q <= m;
        k_q <= k;
        rem_q <= '0;
        pos_q <= '0;
        c_q <= (m == MW'(1)) ? '0 : MW'(1);
        bit_q <= '0;
        pcnt_q <= PW'(1);
      end else if (cmd_i.mod_step) begin
        rem_q <= rem_nxt;
        pos_q <= rem_nxt;
        c_q <= pw_nxt;
        // rotate so the hash is back in place after the last bit
        h_q <= {h_q[HashWidth-2:0], h_q[HashWidth-1]};
        bit_q <= bit_q + HcW'(1);
      end else if (cmd_i.advance) begin
        sum_q <= sum_add[HashWidth-1:0];
        pos_q <= pos_nxt;
        pcnt_q <= pcnt_q + PW'(1);
      end
      if (cmd_i.probe) stepc_q <= stepc_nxt;
    end
  end

  // bit store, one access per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem_q[clr_q] <= 1'b0;
    else if (cmd_i.mark) mem_q[addr] <= 1'b1;
    if (cmd_i.probe) rd_q <= mem_q[addr];
  end

  always_comb begin
    sts_o.mod_last = (bit_q == HcW'(HashWidth - 1));
    sts_o.clr_last = (clr_q == AW'(MaxBits - 1));
    sts_o.probe_last = (pcnt_q == k_q);
    sts_o.bit_hit = rd_q;
    sts_o.is_query = act_q;
  end
  assign set_bit_count_o = ones_q[CountWidth-1:0];
endmodule

>>> sv/bfba_ctrl.sv
// sequencer for clearing, load, modulo, probes and result hand-off
module bfba_ctrl import bfba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      maybe_present_o,
  output bfba_cmd_t cmd_o,
  input  bfba_sts_t sts_i
);
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StMod = 3'd2;
  localparam logic [2:0] StProbe = 3'd3;
  localparam logic [2:0] StCheck = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic pres_q, pres_d;

  always_comb begin
    state_d = state_q;
    pres_d = pres_q;
    cmd_o = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = StMod;
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = StProbe;
      end
      StProbe: begin
        cmd_o.probe = 1'b1;
        state_d = StCheck;
      end
      StCheck: begin
        if (sts_i.is_query && !sts_i.bit_hit) begin
          pres_d = 1'b0;
          state_d = StDone;
        end else begin
          cmd_o.mark = !sts_i.is_query && !sts_i.bit_hit;
          if (sts_i.probe_last) begin
            pres_d = sts_i.is_query;
            state_d = StDone;
          end else begin
            cmd_o.advance = 1'b1;
            state_d = StProbe;
          end
        end
      end
      StDone: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      pres_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pres_q <= pres_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign maybe_present_o = pres_q;

  `include "bloom_filter_bit_array_unit_assert.svh"
  `BF_ASSERT(a_one_side, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `BF_ASSERT_NEXT(a_accept_mod, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StMod)
  `BF_ASSERT_NEXT(a_hold_done, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
